// ----- src/pvd_pkg.sv -----
`default_nettype none

package pvd_pkg;

  localparam int unsigned SAMPLE_W   = 25;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned DIFF_W     = 26;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned BASE_W     = 41;
  localparam int unsigned THR_W      = 20;
  localparam int unsigned HOLD_W     = 16;
  localparam int unsigned ALPHA_W    = 16;
  localparam int unsigned PROD_W     = SAMPLE_W + ALPHA_W;
  localparam int unsigned CLS_W      = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = 2;

  localparam logic [THR_W-1:0]   DETECT_THR_RST = 20'd7680;
  localparam logic [THR_W-1:0]   MEDIUM_THR_RST = 20'd12800;
  localparam logic [THR_W-1:0]   LARGE_THR_RST  = 20'd20480;
  localparam logic [HOLD_W-1:0]  HOLDOFF_RST    = 16'd2000;
  localparam logic [ALPHA_W-1:0] ALPHA_RST      = 16'd655;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DETECT_THR = 3'd0,
    CFG_MEDIUM_THR = 3'd1,
    CFG_LARGE_THR  = 3'd2,
    CFG_HOLDOFF    = 3'd3,
    CFG_ALPHA      = 3'd4
  } cfg_idx_e;

  typedef enum logic [CLS_W-1:0] {
    CLS_SMALL = 2'd0,
    CLS_CAR   = 2'd1,
    CLS_LARGE = 2'd2
  } cls_e;

  // seed carries the calibration sum, track carries a sample to process
  typedef enum logic {
    KIND_SEED  = 1'b0,
    KIND_TRACK = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e               kind;
    logic [SAMPLE_W-1:0] sample;
    logic [TIME_W-1:0]   time_ms;
    logic [PROD_W-1:0]   prod;
  } entry_t;

  typedef struct packed {
    logic [THR_W-1:0]   detect_thr;
    logic [THR_W-1:0]   medium_thr;
    logic [THR_W-1:0]   large_thr;
    logic [HOLD_W-1:0]  holdoff;
    logic [ALPHA_W-1:0] alpha;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [BASE_W-1:0] quot;
  } div_res_t;

endpackage

`default_nettype wire

// ----- src/pressure_vehicle_detector_unit.sv -----
// Throughput: one word per cycle unless the output stalls, set by the baseline
// update in the back end (one 41x16 multiply and add per cycle). After the
// last calibration word the back end holds its queue while a three-digit
// reciprocal divider seeds the baseline. Reset: asynchronous, active low;
// clears calibration, baseline, last detect time, queue and output valid,
// and loads the defaults.
`default_nettype none

module pressure_vehicle_detector_unit #(
  parameter int unsigned CALIB_SAMPLES = 10
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [pvd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [pvd_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic [pvd_pkg::SAMPLE_W-1:0]     pressure_sample_i,
  input  wire logic [pvd_pkg::TIME_W-1:0]       time_ms_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic                                  detected_o,
  output logic [pvd_pkg::CLS_W-1:0]             vehicle_class_o,
  output logic signed [pvd_pkg::DIFF_W-1:0]     difference_o,
  output logic [pvd_pkg::SAMPLE_W-1:0]          baseline_out_o
);
  import pvd_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic       push;
  logic       pop;
  entry_t     wentry;
  entry_t     rentry;
  fifo_stat_t fifo_stat;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DETECT_THR: cfg_d.detect_thr = cfg_data_i;
        CFG_MEDIUM_THR: cfg_d.medium_thr = cfg_data_i;
        CFG_LARGE_THR:  cfg_d.large_thr  = cfg_data_i;
        CFG_HOLDOFF:    cfg_d.holdoff    = cfg_data_i[HOLD_W-1:0];
        CFG_ALPHA:      cfg_d.alpha      = cfg_data_i[ALPHA_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.detect_thr <= DETECT_THR_RST;
      cfg_q.medium_thr <= MEDIUM_THR_RST;
      cfg_q.large_thr  <= LARGE_THR_RST;
      cfg_q.holdoff    <= HOLDOFF_RST;
      cfg_q.alpha      <= ALPHA_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign in_stall_o = fifo_stat.full;

  pvd_front #(
    .CALIB_SAMPLES(CALIB_SAMPLES)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .full_i    (fifo_stat.full),
    .sample_i  (pressure_sample_i),
    .time_i    (time_ms_i),
    .alpha_i   (cfg_q.alpha),
    .push_o    (push),
    .entry_o   (wentry)
  );

  pvd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i(wentry),
    .pop_i  (pop),
    .rdata_o(rentry),
    .stat_o (fifo_stat)
  );

  pvd_back #(
    .CALIB_SAMPLES(CALIB_SAMPLES)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .entry_i        (rentry),
    .fifo_i         (fifo_stat),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .detected_o     (detected_o),
    .vehicle_class_o(vehicle_class_o),
    .difference_o   (difference_o),
    .baseline_out_o (baseline_out_o)
  );

endmodule

`default_nettype wire

// ----- src/pvd_front.sv -----
`default_nettype none

module pvd_front #(
  parameter int unsigned CALIB_SAMPLES = 10
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  input  wire logic                           full_i,
  input  wire logic [pvd_pkg::SAMPLE_W-1:0]   sample_i,
  input  wire logic [pvd_pkg::TIME_W-1:0]     time_i,
  input  wire logic [pvd_pkg::ALPHA_W-1:0]    alpha_i,
  output logic                                push_o,
  output pvd_pkg::entry_t                     entry_o
);
  import pvd_pkg::*;

  localparam int unsigned CNT_W = $clog2(CALIB_SAMPLES + 1);
  localparam int unsigned SUM_W = SAMPLE_W + $clog2(CALIB_SAMPLES);

  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic              accept;
  logic              tracking;
  logic              last_calib;
  logic [PROD_W-1:0] prod;

  assign accept     = in_valid_i & ~full_i;
  assign tracking   = (cnt_q == CNT_W'(CALIB_SAMPLES));
  assign last_calib = (cnt_q == CNT_W'(CALIB_SAMPLES - 1));
  assign prod       = PROD_W'(sample_i) * PROD_W'(alpha_i);

  always_comb begin
    cnt_d = cnt_q;
    sum_d = sum_q;
    if (accept && !tracking) begin
      cnt_d = cnt_q + 1'b1;
      sum_d = sum_q + SUM_W'(sample_i);
    end
  end

  // calibration words stay here; the last one hands the sum on as a seed
  assign push_o = accept & (tracking | last_calib);

  always_comb begin
    entry_o.kind    = tracking ? KIND_TRACK : KIND_SEED;
    entry_o.sample  = sample_i;
    entry_o.time_ms = time_i;
    entry_o.prod    = tracking ? prod : PROD_W'(sum_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      sum_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      sum_q <= sum_d;
    end
  end

endmodule

`default_nettype wire

// ----- src/pvd_fifo.sv -----
`default_nettype none

module pvd_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  pvd_pkg::entry_t     wdata_i,
  input  wire logic           pop_i,
  output pvd_pkg::entry_t     rdata_o,
  output pvd_pkg::fifo_stat_t stat_o
);
  import pvd_pkg::*;

  logic [FIFO_AW-1:0] wr_q, rd_q;
  logic [FIFO_AW:0]   cnt_q;
  entry_t             mem_q [FIFO_DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  assign rdata_o      = mem_q[rd_q];
  assign stat_o.full  = (cnt_q == (FIFO_AW + 1)'(FIFO_DEPTH));
  assign stat_o.empty = (cnt_q == '0);

endmodule

`default_nettype wire

// ----- src/pvd_div.sv -----
`default_nettype none

module pvd_div #(
  parameter int unsigned CALIB_SAMPLES = 10
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [pvd_pkg::PROD_W-1:0] dividend_i,
  output pvd_pkg::div_res_t               res_o
);
  import pvd_pkg::*;

  localparam int unsigned CNT_W   = $clog2(CALIB_SAMPLES + 1);
  localparam int unsigned SUM_W   = SAMPLE_W + $clog2(CALIB_SAMPLES);
  localparam int unsigned CHUNK_W = 15;
  localparam int unsigned STEPS   = (SUM_W + FRAC_W + CHUNK_W - 1) / CHUNK_W;
  localparam int unsigned DIV_W   = STEPS * CHUNK_W;
  localparam int unsigned STEP_W  = $clog2(STEPS);
  localparam int unsigned CUR_W   = CNT_W + CHUNK_W;
  localparam int unsigned SHIFT   = CUR_W + CNT_W;
  localparam int unsigned RECIP_W = SHIFT + 1;
  localparam int unsigned MUL_W   = CUR_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << SHIFT) + 64'(CALIB_SAMPLES) - 64'd1) / 64'(CALIB_SAMPLES));

  logic               busy_q;
  logic               done_q;
  logic [STEP_W-1:0]  step_q;
  logic [CNT_W-1:0]   rem_q;
  logic [DIV_W-1:0]   work_q;
  logic [CUR_W-1:0]   cur;
  logic [MUL_W-1:0]   recip_prod;
  logic [CHUNK_W-1:0] digit;
  logic [CUR_W-1:0]   back_prod;
  logic [CNT_W-1:0]   rem_d;
  logic               last_step;

  // long division by the constant, one 15-bit digit a cycle; the digit comes
  // from an exact reciprocal multiply, the remainder from multiplying back
  assign cur        = {rem_q, work_q[DIV_W-1 -: CHUNK_W]};
  assign recip_prod = MUL_W'(cur) * MUL_W'(RECIP);
  assign digit      = recip_prod[SHIFT +: CHUNK_W];
  assign back_prod  = CUR_W'(digit) * CUR_W'(CALIB_SAMPLES);
  assign rem_d      = CNT_W'(cur - back_prod);
  assign last_step  = (step_q == STEP_W'(STEPS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= busy_q & last_step;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (last_step) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      work_q <= DIV_W'({SUM_W'(dividend_i), FRAC_W'(0)});
      rem_q  <= '0;
    end else if (busy_q) begin
      work_q <= {work_q[DIV_W-CHUNK_W-1:0], digit};
      rem_q  <= rem_d;
    end
  end

  assign res_o.busy = busy_q | done_q;
  assign res_o.done = done_q;
  assign res_o.quot = work_q[BASE_W-1:0];

endmodule

`default_nettype wire

// ----- src/pvd_back.sv -----
`default_nettype none

module pvd_back #(
  parameter int unsigned CALIB_SAMPLES = 10
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  pvd_pkg::cfg_t                      cfg_i,
  input  pvd_pkg::entry_t                    entry_i,
  input  pvd_pkg::fifo_stat_t                fifo_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               detected_o,
  output logic [pvd_pkg::CLS_W-1:0]          vehicle_class_o,
  output logic signed [pvd_pkg::DIFF_W-1:0]  difference_o,
  output logic [pvd_pkg::SAMPLE_W-1:0]       baseline_out_o
);
  import pvd_pkg::*;

  localparam int unsigned ACC_W = BASE_W + FRAC_W + 1;

  logic [BASE_W-1:0]         base_q, base_d;
  logic [TIME_W-1:0]         last_q, last_d;
  logic                      out_valid_q;
  logic                      det_q;
  cls_e                      cls_q;
  logic signed [DIFF_W-1:0]  diff_q;
  logic [SAMPLE_W-1:0]       bout_q;

  logic                      out_ready;
  logic                      is_seed;
  logic                      take;
  logic                      seed_start;
  logic                      track;
  div_res_t                  div_res;

  logic [SAMPLE_W-1:0]       base_cur;
  logic signed [DIFF_W-1:0]  diff;
  logic [DIFF_W-1:0]         mag;
  logic [TIME_W-1:0]         elapsed;
  logic                      det;
  cls_e                      cls;
  logic [BASE_W+ALPHA_W-1:0] scaled;
  logic [ACC_W-1:0]          acc;
  logic [BASE_W-1:0]         new_base;

  assign out_ready  = ~out_valid_q | ~out_stall_i;
  assign is_seed    = (entry_i.kind == KIND_SEED);
  // hold the queue while the baseline is being seeded
  assign take       = ~fifo_i.empty & ~div_res.busy & (is_seed | out_ready);
  assign pop_o      = take;
  assign seed_start = take & is_seed;
  assign track      = take & ~is_seed;

  pvd_div #(
    .CALIB_SAMPLES(CALIB_SAMPLES)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (seed_start),
    .dividend_i(entry_i.prod),
    .res_o     (div_res)
  );

  assign base_cur = base_q[BASE_W-1 -: SAMPLE_W];
  assign diff     = signed'({1'b0, entry_i.sample}) - signed'({1'b0, base_cur});
  assign mag      = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
  assign elapsed  = entry_i.time_ms - last_q;
  assign det      = (elapsed > TIME_W'(cfg_i.holdoff)) && (mag > DIFF_W'(cfg_i.detect_thr));

  always_comb begin
    if (!det) begin
      cls = CLS_SMALL;
    end else if (mag > DIFF_W'(cfg_i.large_thr)) begin
      cls = CLS_LARGE;
    end else if (mag > DIFF_W'(cfg_i.medium_thr)) begin
      cls = CLS_CAR;
    end else begin
      cls = CLS_SMALL;
    end
  end

  // new = ((base << 16) + (alpha * sample << 16) - alpha * base) >> 16
  assign scaled   = (BASE_W + ALPHA_W)'(base_q) * (BASE_W + ALPHA_W)'(cfg_i.alpha);
  assign acc      = {1'b0, base_q, FRAC_W'(0)} + {1'b0, entry_i.prod, FRAC_W'(0)}
                  - ACC_W'(scaled);
  assign new_base = acc[BASE_W+FRAC_W-1:FRAC_W];

  always_comb begin
    base_d = base_q;
    last_d = last_q;
    if (div_res.done) begin
      base_d = div_res.quot;
    end else if (track) begin
      base_d = new_base;
      if (det) begin
        last_d = entry_i.time_ms;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      base_q <= base_d;
      last_q <= last_d;
      if (track) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (track) begin
      det_q  <= det;
      cls_q  <= cls;
      diff_q <= diff;
      bout_q <= base_cur;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign detected_o      = det_q;
  assign vehicle_class_o = cls_q;
  assign difference_o    = diff_q;
  assign baseline_out_o  = bout_q;

endmodule

`default_nettype wire
